### rtl/rbfk_pkg.sv
// Package for the 2D squared-exponential kernel and gradient block.
// Holds the item structs, stage payload structs, register indexes and fixed-point constants.
// Depends on nothing; every other file of the block imports it.
package rbfk_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int MAG_WIDTH    = COORD_WIDTH + 1;
   localparam int SQ_IN_WIDTH  = 15;
   localparam int SQ_WIDTH     = 2 * SQ_IN_WIDTH;
   localparam int D2_WIDTH     = SQ_WIDTH + 1;
   localparam int CFG_WIDTH    = 16;
   localparam int X_WIDTH      = CFG_WIDTH + SQ_WIDTH;
   localparam int X_RANGE      = 41;
   localparam int LOG2E_WIDTH  = 21;
   localparam int B_WIDTH      = X_RANGE + LOG2E_WIDTH;
   localparam int FRAC_WIDTH   = 45;
   localparam int SHIFT_WIDTH  = 5;
   localparam int WEIGHT_WIDTH = 16;
   localparam int E_WIDTH      = 33;
   localparam int G_WIDTH      = 2 * CFG_WIDTH;
   localparam int M_WIDTH      = G_WIDTH + E_WIDTH - 16;
   localparam int M_LO_WIDTH   = 24;
   localparam int M_HI_WIDTH   = M_WIDTH - M_LO_WIDTH;
   localparam int PL_WIDTH     = M_LO_WIDTH + MAG_WIDTH;
   localparam int PH_WIDTH     = M_HI_WIDTH + MAG_WIDTH;
   localparam int COV_WIDTH    = 24;
   localparam int GRAD_WIDTH   = 32;
   localparam int CSR_INDEX_WIDTH = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIGNAL_VARIANCE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INV_LENGTH_SQ   = 8'd1;

   localparam logic [CFG_WIDTH-1:0] SIGNAL_VARIANCE_RESET = 16'd256;
   localparam logic [CFG_WIDTH-1:0] INV_LENGTH_SQ_RESET   = 16'd256;

   localparam logic [63:0] LN2_Q32 = 64'd2977044472;
   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam logic [LOG2E_WIDTH-1:0] LOG2E_Q20 = 21'd1512775;
   localparam logic [23:0] ROUND_Q24 = 24'h80_0000;
   localparam logic [GRAD_WIDTH-1:0] GRAD_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [GRAD_WIDTH-1:0] GRAD_NEG_MAG = 32'h8000_0000;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] basis_x;
      logic signed [COORD_WIDTH-1:0] basis_y;
   } req_type;

   typedef struct packed {
      logic [COV_WIDTH-1:0]         covariance;
      logic signed [GRAD_WIDTH-1:0] grad_x;
      logic signed [GRAD_WIDTH-1:0] grad_y;
   } rsp_type;

   // Offset sign and magnitude, carried alongside the exponent path.
   typedef struct packed {
      logic                 neg_x;
      logic                 neg_y;
      logic [MAG_WIDTH-1:0] mag_x;
      logic [MAG_WIDTH-1:0] mag_y;
   } side_type;

   typedef struct packed {
      logic               ok;
      logic [B_WIDTH-1:0] b;
      side_type           side;
   } arg_type;

   typedef struct packed {
      logic [E_WIDTH-1:0] e;
      side_type           side;
   } decay_type;

endpackage

### rtl/rbfk_dist.sv
// Offset, squared distance and exponent argument stages of the kernel pipeline.
// Four register stages; depends on rbfk_pkg.
module rbfk_dist (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  rbfk_pkg::req_type           in_item,
   input  logic [rbfk_pkg::CFG_WIDTH-1:0] inv_length_sq,
   output logic                        out_valid,
   output rbfk_pkg::arg_type           out_arg
);
   import rbfk_pkg::*;

   logic signed [MAG_WIDTH-1:0] ox, oy;
   side_type side1_in, side1_ff, side2_ff, side3_ff, side4_ff;
   logic near1_in, near1_ff, near2_ff;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic [SQ_WIDTH-1:0] sx_in, sy_in, sx_ff, sy_ff;
   logic [D2_WIDTH-1:0] d2;
   logic ok3_in, ok3_ff, ok4_in, ok4_ff;
   logic [X_WIDTH-1:0] x_in, x_ff;
   logic [B_WIDTH-1:0] b_in, b_ff;

   always_comb begin
      ox = MAG_WIDTH'(in_item.point_x) - MAG_WIDTH'(in_item.basis_x);
      oy = MAG_WIDTH'(in_item.point_y) - MAG_WIDTH'(in_item.basis_y);
      side1_in.neg_x = ox[MAG_WIDTH-1];
      side1_in.neg_y = oy[MAG_WIDTH-1];
      side1_in.mag_x = ox[MAG_WIDTH-1] ? MAG_WIDTH'(-ox) : MAG_WIDTH'(ox);
      side1_in.mag_y = oy[MAG_WIDTH-1] ? MAG_WIDTH'(-oy) : MAG_WIDTH'(oy);
      // A component of 2^15 or more already puts d2 past the table range.
      near1_in = (side1_in.mag_x[MAG_WIDTH-1:SQ_IN_WIDTH] == '0) &&
                 (side1_in.mag_y[MAG_WIDTH-1:SQ_IN_WIDTH] == '0);
   end

   always_comb begin
      sx_in = SQ_WIDTH'(side1_ff.mag_x[SQ_IN_WIDTH-1:0]) *
              SQ_WIDTH'(side1_ff.mag_x[SQ_IN_WIDTH-1:0]);
      sy_in = SQ_WIDTH'(side1_ff.mag_y[SQ_IN_WIDTH-1:0]) *
              SQ_WIDTH'(side1_ff.mag_y[SQ_IN_WIDTH-1:0]);
   end

   always_comb begin
      d2     = D2_WIDTH'(sx_ff) + D2_WIDTH'(sy_ff);
      ok3_in = near2_ff && !d2[D2_WIDTH-1];
      x_in   = X_WIDTH'(inv_length_sq) * X_WIDTH'(d2[SQ_WIDTH-1:0]);
   end

   always_comb begin
      ok4_in = ok3_ff && (x_ff[X_WIDTH-1:X_RANGE] == '0);
      b_in   = B_WIDTH'(x_ff[X_RANGE-1:0]) * B_WIDTH'(LOG2E_Q20);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      side1_ff <= side1_in;
      near1_ff <= near1_in;
      side2_ff <= side1_ff;
      near2_ff <= near1_ff;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      side3_ff <= side2_ff;
      ok3_ff   <= ok3_in;
      x_ff     <= x_in;
      side4_ff <= side3_ff;
      ok4_ff   <= ok4_in;
      b_ff     <= b_in;
   end

   assign out_valid    = v4_ff;
   assign out_arg.ok   = ok4_ff;
   assign out_arg.b    = b_ff;
   assign out_arg.side = side4_ff;

endmodule

### rtl/rbfk_exp.sv
// Power-of-two decay stages: table index, table read, interpolation and final shift.
// Four register stages with a constant table built at elaboration; depends on rbfk_pkg.
module rbfk_exp #(
   parameter int EXP_TABLE_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rbfk_pkg::arg_type   in_arg,
   output logic                out_valid,
   output rbfk_pkg::decay_type out_decay
);
   import rbfk_pkg::*;

   localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int SW = FRAC_WIDTH + IW;
   localparam logic [IW-1:0] LAST_INDEX = IW'(EXP_TABLE_DEPTH - 1);

   // Entry j holds 2^(-j/depth) in Q.32 from a truncated 15-term series.
   logic [E_WIDTH-1:0] exp_tab [EXP_TABLE_DEPTH+1];

   for (genvar j = 0; j <= EXP_TABLE_DEPTH; j++) begin : gen_tab
      localparam logic [63:0] Y   = (64'(j) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
      localparam logic [63:0] T1  = ((ONE_Q32 * Y) >> 32) / 64'd1;
      localparam logic [63:0] T2  = ((T1 * Y) >> 32) / 64'd2;
      localparam logic [63:0] T3  = ((T2 * Y) >> 32) / 64'd3;
      localparam logic [63:0] T4  = ((T3 * Y) >> 32) / 64'd4;
      localparam logic [63:0] T5  = ((T4 * Y) >> 32) / 64'd5;
      localparam logic [63:0] T6  = ((T5 * Y) >> 32) / 64'd6;
      localparam logic [63:0] T7  = ((T6 * Y) >> 32) / 64'd7;
      localparam logic [63:0] T8  = ((T7 * Y) >> 32) / 64'd8;
      localparam logic [63:0] T9  = ((T8 * Y) >> 32) / 64'd9;
      localparam logic [63:0] T10 = ((T9 * Y) >> 32) / 64'd10;
      localparam logic [63:0] T11 = ((T10 * Y) >> 32) / 64'd11;
      localparam logic [63:0] T12 = ((T11 * Y) >> 32) / 64'd12;
      localparam logic [63:0] T13 = ((T12 * Y) >> 32) / 64'd13;
      localparam logic [63:0] T14 = ((T13 * Y) >> 32) / 64'd14;
      localparam logic [63:0] POS = ONE_Q32 + T2 + T4 + T6 + T8 + T10 + T12 + T14;
      localparam logic [63:0] NEG = T1 + T3 + T5 + T7 + T9 + T11 + T13;
      localparam logic [63:0] VAL = POS - NEG;
      assign exp_tab[j] = VAL[E_WIDTH-1:0];
   end

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   side_type side1_ff, side2_ff, side3_ff, side4_ff;
   logic ok1_in, ok1_ff, ok2_ff, ok3_ff;
   logic [SHIFT_WIDTH-1:0] k1_ff, k2_ff, k3_ff;
   logic [SW-1:0] s1_in, s1_ff;
   logic [IW-1:0] idx;
   logic [E_WIDTH-1:0] hi_in, lo_in, hi_ff, lo_ff;
   logic [WEIGHT_WIDTH-1:0] w_in, w_ff;
   logic [E_WIDTH-1:0] diff;
   logic [E_WIDTH+WEIGHT_WIDTH-1:0] prod;
   logic [E_WIDTH-1:0] f_in, f_ff;
   logic [E_WIDTH-1:0] e_in, e_ff;

   always_comb begin
      // The integer part of the exponent must stay below 32.
      ok1_in = in_arg.ok && (in_arg.b[B_WIDTH-1:FRAC_WIDTH+SHIFT_WIDTH] == '0);
      s1_in  = SW'(in_arg.b[FRAC_WIDTH-1:0]) * SW'(EXP_TABLE_DEPTH);
   end

   always_comb begin
      idx = s1_ff[SW-1:FRAC_WIDTH];
      if (idx > LAST_INDEX) begin
         idx = LAST_INDEX;
      end
      hi_in = exp_tab[idx];
      lo_in = exp_tab[idx + IW'(1)];
      w_in  = s1_ff[FRAC_WIDTH-1:FRAC_WIDTH-WEIGHT_WIDTH];
   end

   always_comb begin
      diff = hi_ff - lo_ff;
      prod = (E_WIDTH+WEIGHT_WIDTH)'(diff) * (E_WIDTH+WEIGHT_WIDTH)'(w_ff);
      f_in = (hi_ff >= lo_ff) ? hi_ff - prod[E_WIDTH+WEIGHT_WIDTH-1:WEIGHT_WIDTH] : hi_ff;
   end

   always_comb begin
      e_in = ok3_ff ? (f_ff >> k3_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      side1_ff <= in_arg.side;
      ok1_ff   <= ok1_in;
      k1_ff    <= in_arg.b[FRAC_WIDTH+SHIFT_WIDTH-1:FRAC_WIDTH];
      s1_ff    <= s1_in;
      side2_ff <= side1_ff;
      ok2_ff   <= ok1_ff;
      k2_ff    <= k1_ff;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      w_ff     <= w_in;
      side3_ff <= side2_ff;
      ok3_ff   <= ok2_ff;
      k3_ff    <= k2_ff;
      f_ff     <= f_in;
      side4_ff <= side3_ff;
      e_ff     <= e_in;
   end

   assign out_valid      = v4_ff;
   assign out_decay.e    = e_ff;
   assign out_decay.side = side4_ff;

endmodule

### rtl/rbfk_scale.sv
// Output stages: covariance scaling, gradient products split in two halves, saturation.
// Three register stages ending in the result register; depends on rbfk_pkg.
module rbfk_scale (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rbfk_pkg::CFG_WIDTH-1:0] signal_variance,
   input  logic [rbfk_pkg::CFG_WIDTH-1:0] inv_length_sq,
   input  logic                           in_valid,
   input  rbfk_pkg::decay_type            in_decay,
   output logic                           out_valid,
   output rbfk_pkg::rsp_type              out_item
);
   import rbfk_pkg::*;

   localparam int CP_WIDTH = CFG_WIDTH + E_WIDTH;
   localparam int MP_WIDTH = G_WIDTH + E_WIDTH;

   function automatic logic [GRAD_WIDTH-1:0] sat_grad(input logic [PH_WIDTH-1:0] ph,
                                                      input logic [PL_WIDTH-1:0] pl,
                                                      input logic neg);
      logic [PL_WIDTH:0]   rnd;
      logic [PH_WIDTH:0]   q;
      logic [GRAD_WIDTH-1:0] mag;
      rnd = (PL_WIDTH+1)'(pl) + (PL_WIDTH+1)'(ROUND_Q24);
      q   = (PH_WIDTH+1)'(ph) + (PH_WIDTH+1)'(rnd[PL_WIDTH:M_LO_WIDTH]);
      if (neg) begin
         // Negative offset gives a positive gradient.
         mag = (q > (PH_WIDTH+1)'(GRAD_POS_MAX)) ? GRAD_POS_MAX : q[GRAD_WIDTH-1:0];
         return mag;
      end else begin
         mag = (q > (PH_WIDTH+1)'(GRAD_NEG_MAG)) ? GRAD_NEG_MAG : q[GRAD_WIDTH-1:0];
         return GRAD_WIDTH'(-mag);
      end
   endfunction

   logic [G_WIDTH-1:0] g_in, g_ff;
   logic v1_ff, v2_ff, out_valid_ff;
   side_type side1_ff, side2_ff;
   logic [CP_WIDTH-1:0] covp;
   logic [CP_WIDTH-M_LO_WIDTH-1:0] covr;
   logic [COV_WIDTH-1:0] cov_in, cov1_ff, cov2_ff;
   logic [MP_WIDTH-1:0] mprod;
   logic [M_WIDTH-1:0] m_in, m_ff;
   logic [PL_WIDTH-1:0] plx_in, ply_in, plx_ff, ply_ff;
   logic [PH_WIDTH-1:0] phx_in, phy_in, phx_ff, phy_ff;
   rsp_type out_item_in, out_item_ff;

   assign g_in = G_WIDTH'(signal_variance) * G_WIDTH'(inv_length_sq);

   always_comb begin
      covp   = CP_WIDTH'(signal_variance) * CP_WIDTH'(in_decay.e);
      covr   = (CP_WIDTH-M_LO_WIDTH)'((covp + CP_WIDTH'(ROUND_Q24)) >> M_LO_WIDTH);
      cov_in = (covr[CP_WIDTH-M_LO_WIDTH-1:COV_WIDTH] != '0) ? '1 : covr[COV_WIDTH-1:0];
      mprod  = MP_WIDTH'(g_ff) * MP_WIDTH'(in_decay.e);
      m_in   = mprod[MP_WIDTH-1:16];
   end

   always_comb begin
      plx_in = PL_WIDTH'(m_ff[M_LO_WIDTH-1:0]) * PL_WIDTH'(side1_ff.mag_x);
      ply_in = PL_WIDTH'(m_ff[M_LO_WIDTH-1:0]) * PL_WIDTH'(side1_ff.mag_y);
      phx_in = PH_WIDTH'(m_ff[M_WIDTH-1:M_LO_WIDTH]) * PH_WIDTH'(side1_ff.mag_x);
      phy_in = PH_WIDTH'(m_ff[M_WIDTH-1:M_LO_WIDTH]) * PH_WIDTH'(side1_ff.mag_y);
   end

   always_comb begin
      out_item_in.covariance = cov2_ff;
      out_item_in.grad_x     = sat_grad(phx_ff, plx_ff, side2_ff.neg_x);
      out_item_in.grad_y     = sat_grad(phy_ff, ply_ff, side2_ff.neg_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         out_valid_ff <= v2_ff;
      end
      g_ff        <= g_in;
      side1_ff    <= in_decay.side;
      cov1_ff     <= cov_in;
      m_ff        <= m_in;
      side2_ff    <= side1_ff;
      cov2_ff     <= cov1_ff;
      plx_ff      <= plx_in;
      ply_ff      <= ply_in;
      phx_ff      <= phx_in;
      phy_ff      <= phy_in;
      out_item_ff <= out_item_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

### rtl/rbf_kernel_and_gradient_2d_top.sv
// Top level of the 2D squared-exponential kernel and gradient block.
// Holds the two configuration registers and chains rbfk_dist, rbfk_exp and rbfk_scale.
// Depends on rbfk_pkg and the three pipeline modules.
//
// Usage:
//   Each item on req_item is one pair of a data point and a basis vector, all four
//   coordinates signed Q8.8. An item is taken at a rising edge where start is high
//   and busy is low. busy is low except while reset is asserted, so one item can
//   be taken in every cycle.
//   For every item exactly one result leaves on rsp_item: the covariance (unsigned
//   Q8.16) and the two gradient components (signed Q16.16, saturating). rsp_valid
//   marks it for a single cycle; the receiver has no way to hold it off.
//   Throughput is one item per cycle: the eleven register stages never stall, and no
//   stage chains more than one multiplication (the widest is the 32 by 33 bit product
//   of the gradient scale with the decay, and the gradient product is split in halves).
//   The decay table is a constant built at elaboration, so no fill is needed.
//   The csr channel writes signal_variance (index 0) and inv_length_sq (index 1);
//   it is always ready, and other indexes are dropped. Write it only while no item
//   is in flight. Reset empties the pipeline and sets both registers to 1.0.
module rbf_kernel_and_gradient_2d_top #(
   parameter int EXP_TABLE_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  rbfk_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   output rbfk_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rbfk_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rbfk_pkg::CFG_WIDTH-1:0]        csr_data
);
   import rbfk_pkg::*;

   logic [CFG_WIDTH-1:0] sv_in, sv_ff, ils_in, ils_ff;
   logic accept;
   logic dist_valid, exp_valid;
   arg_type dist_arg;
   decay_type exp_decay;

   // The pipeline never stalls; items are refused only while reset is held.
   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_comb begin
      sv_in  = sv_ff;
      ils_in = ils_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SIGNAL_VARIANCE: sv_in  = csr_data;
            CSR_INV_LENGTH_SQ:   ils_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff  <= SIGNAL_VARIANCE_RESET;
         ils_ff <= INV_LENGTH_SQ_RESET;
      end else begin
         sv_ff  <= sv_in;
         ils_ff <= ils_in;
      end
   end

   // Offsets, squared norm and the base-two exponent argument.
   rbfk_dist u_dist (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .in_item       (req_item),
      .inv_length_sq (ils_ff),
      .out_valid     (dist_valid),
      .out_arg       (dist_arg)
   );

   // Interpolated table lookup of the fraction, then the shift by the integer part.
   rbfk_exp #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dist_valid),
      .in_arg    (dist_arg),
      .out_valid (exp_valid),
      .out_decay (exp_decay)
   );

   // Scaling by the kernel variance and the gradient factor, with saturation.
   rbfk_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .signal_variance (sv_ff),
      .inv_length_sq   (ils_ff),
      .in_valid        (exp_valid),
      .in_decay        (exp_decay),
      .out_valid       (rsp_valid),
      .out_item        (rsp_item)
   );

endmodule
